/* rtl/core/bounded_domain_pattern_match_assert.svh */
// -----------------------------------------------------------------------------
// Assertion macros for the bounded domain pattern matcher
// Same-cycle and next-cycle implication checks, disabled while in reset.
// -----------------------------------------------------------------------------
`ifndef BOUNDED_DOMAIN_PATTERN_MATCH_ASSERT_SVH
`define BOUNDED_DOMAIN_PATTERN_MATCH_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define BDPM_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define BDPM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/bdpm_pkg.sv */
// -----------------------------------------------------------------------------
// Bounded domain pattern matcher package
// Item kinds, boundary bytes and the control and status bundles.
// -----------------------------------------------------------------------------
`default_nettype none

package bdpm_pkg;

  // item kinds on the input channel
  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_URL    = 2'd2
  } kind_e;

  // boundary bytes
  localparam logic [7:0] DOT_BYTE   = 8'h2E;
  localparam logic [7:0] SLASH_BYTE = 8'h2F;

  // control from the sequencing logic to the match unit
  typedef struct packed {
    logic       clear;
    logic       append;
    logic       url;
    logic       url_last;
    logic [7:0] ch;
  } match_ctl_t;

  // status from the match unit
  typedef struct packed {
    logic seen_zero;
    logic len_zero;
    logic here;
    logic trunc;
  } match_stat_t;

endpackage

`default_nettype wire

/* rtl/core/bdpm_if.sv */
// -----------------------------------------------------------------------------
// Bounded domain pattern matcher channels
// Valid/ready channels for input items and for results.
// -----------------------------------------------------------------------------
`default_nettype none

interface bdpm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] char_in;
  logic       last;

  modport source (output valid, output kind, output char_in, output last, input ready);
  modport sink (input valid, input kind, input char_in, input last, output ready);
endinterface

interface bdpm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_truncated;

  modport source (output valid, output matched, output pattern_truncated, input ready);
  modport sink (input valid, input matched, input pattern_truncated, output ready);
endinterface

`default_nettype wire

/* rtl/core/bdpm_match.sv */
// -----------------------------------------------------------------------------
// Pattern and window compare unit
// Holds the pattern right-aligned in a shift line and the newest URL bytes in
// a second shift line, and compares them position by position combinationally.
// -----------------------------------------------------------------------------
`default_nettype none

module bdpm_match #(
  parameter int unsigned MAX_PAT = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire bdpm_pkg::match_ctl_t ctl_i,
  output bdpm_pkg::match_stat_t     stat_o
);
  import bdpm_pkg::*;

  localparam int unsigned Window = MAX_PAT + 1;
  localparam int unsigned LenW   = $clog2(MAX_PAT + 1);
  localparam int unsigned SeenW  = $clog2(MAX_PAT + 2);

  // pat_q[0] is the newest pattern byte, win_q[0] the newest URL byte
  logic [7:0]       pat_q [MAX_PAT];
  logic [7:0]       win_q [Window];
  logic [7:0]       win_nx [Window];
  logic [LenW-1:0]  len_q, len_d;
  logic             trunc_q, trunc_d;
  logic [SeenW-1:0] seen_q, seen_d, seen_inc;
  logic [MAX_PAT-1:0] pos_ok;
  logic [Window-1:0]  dot_vec;
  logic             seen_ge, seen_eq;

  // window as it stands after this byte
  always_comb begin
    win_nx[0] = ctl_i.ch;
    for (int k = 1; k < Window; k++) begin
      win_nx[k] = win_q[k-1];
    end
  end

  // saturating byte count
  assign seen_inc = (seen_q == SeenW'(Window)) ? seen_q : seen_q + SeenW'(1);

  // per-position compare, positions beyond the pattern length pass
  always_comb begin
    for (int k = 0; k < MAX_PAT; k++) begin
      pos_ok[k] = (pat_q[k] == win_nx[k]) || (LenW'(k) >= len_q);
    end
    for (int k = 0; k < Window; k++) begin
      dot_vec[k] = (win_nx[k] == DOT_BYTE);
    end
  end

  assign seen_ge = (seen_inc >= SeenW'(len_q));
  assign seen_eq = (seen_inc == SeenW'(len_q));

  // status
  always_comb begin
    stat_o.here      = (&pos_ok) && seen_ge && (seen_eq || dot_vec[len_q]);
    stat_o.seen_zero = (seen_q == '0);
    stat_o.len_zero  = (len_q == '0);
    stat_o.trunc     = trunc_q;
  end

  // length, flag and count next state
  always_comb begin
    len_d   = len_q;
    trunc_d = trunc_q;
    seen_d  = seen_q;
    if (ctl_i.clear) begin
      len_d   = '0;
      trunc_d = 1'b0;
    end
    if (ctl_i.append) begin
      if (len_q < LenW'(MAX_PAT)) begin
        len_d = len_q + LenW'(1);
      end else begin
        trunc_d = 1'b1;
      end
    end
    if (ctl_i.url) begin
      seen_d = ctl_i.url_last ? '0 : seen_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      trunc_q <= 1'b0;
      seen_q  <= '0;
    end else begin
      len_q   <= len_d;
      trunc_q <= trunc_d;
      seen_q  <= seen_d;
    end
  end

  // pattern shift line, shifts on an append with room left
  always_ff @(posedge clk_i) begin
    if (ctl_i.append && (len_q < LenW'(MAX_PAT))) begin
      pat_q[0] <= ctl_i.ch;
      for (int k = 1; k < MAX_PAT; k++) begin
        pat_q[k] <= pat_q[k-1];
      end
    end
  end

  // URL window shift line
  always_ff @(posedge clk_i) begin
    if (ctl_i.url) begin
      for (int k = 0; k < Window; k++) begin
        win_q[k] <= win_nx[k];
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/bounded_domain_pattern_match.sv */
// -----------------------------------------------------------------------------
// Bounded domain pattern matcher
// Loads a pattern and scans URL bytes; at the last URL byte reports whether
// the pattern occurs with a '.' or start boundary before and a '/' or end
// boundary after it.
//
//   channel  dir  payload                      when
//   in_i     in   kind, char_in, last          one transaction per byte
//   out_o    out  matched, pattern_truncated   one transaction per URL
//
// One item is taken every cycle unless a result that is not taken stalls the
// input; a result is registered once the last URL byte has passed the input
// register and then the result register. The compare of the pattern shift
// line against the URL window is combinational. Reset clears all control
// state; pattern and window bytes need no reset. Input ready drops only
// while an item waits in the input register behind a result that is not
// taken.
// -----------------------------------------------------------------------------
`default_nettype none

`include "bounded_domain_pattern_match_assert.svh"

module bounded_domain_pattern_match #(
  parameter int unsigned MAX_PAT = 64
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bdpm_in_if.sink    in_i,
  bdpm_out_if.source out_o
);
  import bdpm_pkg::*;

  logic        in_vld_q, in_vld_d;
  logic [1:0]  kind_q;
  logic [7:0]  char_q;
  logic        last_q;
  logic        out_vld_q, out_vld_d;
  logic        matched_q, trunc_q;
  logic        found_q, found_d, pend_q, pend_d;
  logic        out_stall, proc, pend, found_nx;
  match_ctl_t  ctl;
  match_stat_t stat;

  // handshake
  assign out_stall  = out_vld_q && !out_o.ready;
  assign proc       = in_vld_q && !out_stall;
  assign in_i.ready = !in_vld_q || proc;

  // input register
  always_comb begin
    in_vld_d = in_vld_q;
    if (in_i.valid && in_i.ready) begin
      in_vld_d = 1'b1;
    end else if (proc) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      kind_q <= in_i.kind;
      char_q <= in_i.char_in;
      last_q <= in_i.last;
    end
  end

  // decode the held item
  always_comb begin
    ctl          = '0;
    ctl.ch       = char_q;
    case (kind_q)
      KIND_CLEAR:  ctl.clear  = proc;
      KIND_APPEND: ctl.append = proc;
      KIND_URL: begin
        ctl.url      = proc;
        ctl.url_last = proc && last_q;
      end
      default: ctl = '{clear: 1'b0, append: 1'b0, url: 1'b0, url_last: 1'b0, ch: char_q};
    endcase
  end

  bdpm_match #(
    .MAX_PAT(MAX_PAT)
  ) u_match (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .stat_o (stat)
  );

  // boundary tracking across URL bytes
  assign pend     = stat.seen_zero ? stat.len_zero : pend_q;
  assign found_nx = found_q || (pend && (char_q == SLASH_BYTE));

  always_comb begin
    found_d = found_q;
    pend_d  = pend_q;
    if (ctl.url) begin
      if (ctl.url_last) begin
        found_d = 1'b0;
        pend_d  = 1'b0;
      end else begin
        found_d = found_nx;
        pend_d  = stat.here;
      end
    end
  end

  // result register
  always_comb begin
    out_vld_d = out_vld_q;
    if (ctl.url_last) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.url_last) begin
      matched_q <= found_nx || (stat.here && !stat.len_zero);
      trunc_q   <= stat.trunc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      found_q   <= 1'b0;
      pend_q    <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      found_q   <= found_d;
      pend_q    <= pend_d;
    end
  end

  assign out_o.valid             = out_vld_q;
  assign out_o.matched           = matched_q;
  assign out_o.pattern_truncated = trunc_q;

  // checks
  `BDPM_ASSERT_NEXT(a_no_stray_result, clk_i, rst_ni,
                    proc && !ctl.url_last, !out_vld_q, "result without last URL byte")
  `BDPM_ASSERT_NEXT(a_clear_drops_flag, clk_i, rst_ni,
                    ctl.clear, !stat.trunc, "truncation flag survived a clear")
  `BDPM_ASSERT_SAME(a_ready_only_stalled, clk_i, rst_ni,
                    !in_i.ready, in_vld_q && out_stall, "input stalled without a held result")

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Bounded domain pattern matcher testbench
// Streams pattern loads and URL bytes into the matcher, predicts the verdict
// of every URL with a cycle-free model of the search and checks each result
// transaction in order, with phases of random idling on both channels.
// -----------------------------------------------------------------------------

module tb;
  import bdpm_pkg::*;

  localparam int unsigned PAT_DEPTH   = 64;
  localparam logic [1:0]  KIND_UNUSED = 2'd3;
  localparam int unsigned LONG_HOLD   = 60;
  localparam int unsigned IDLE_LIMIT  = 3000;
  localparam int unsigned DRAIN_WAIT  = 10;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic       last;
  } stream_item_t;

  typedef struct packed {
    logic matched;
    logic pattern_truncated;
  } verdict_t;

  logic clk_i;
  logic rst_ni;

  bdpm_in_if  in_if ();
  bdpm_out_if out_if ();

  bounded_domain_pattern_match #(
    .MAX_PAT(PAT_DEPTH)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  stream_item_t item_q[$];
  verdict_t     verdict_q[$];
  stream_item_t cur_item;
  int unsigned  items_made;
  int unsigned  fail_cnt;
  int unsigned  gap_left;
  int unsigned  stall_left;
  int unsigned  hold_cnt;
  int unsigned  idle_cycles;
  logic         send_idle;
  logic         recv_idle;
  logic         hold_req;

  // matcher state as seen by the predictor
  logic [7:0]  pat_bytes [PAT_DEPTH];
  int unsigned pat_len;
  logic        pat_trunc;
  logic [7:0]  url_win [PAT_DEPTH+1];
  int unsigned url_seen;
  logic        url_found;
  logic        url_pend;

  // pattern as the stimulus believes it is loaded
  logic [7:0]  gen_pat[$];

  // pattern ends at the newest url byte with '.' or url start in front
  function automatic logic pattern_ends_here();
    int unsigned j;
    if (url_seen < pat_len) return 1'b0;
    for (j = 0; j < pat_len; j++) begin
      if (pat_bytes[j] != url_win[pat_len-1-j]) return 1'b0;
    end
    if (url_seen == pat_len) return 1'b1;
    return url_win[pat_len] == DOT_BYTE;
  endfunction

  // update the predicted state for one accepted item, queue the verdict
  function automatic void track_item(input stream_item_t it);
    logic     pend;
    logic     here;
    int       k;
    verdict_t v;
    case (it.kind)
      KIND_CLEAR: begin
        pat_len   = 0;
        pat_trunc = 1'b0;
      end
      KIND_APPEND: begin
        if (pat_len < PAT_DEPTH) begin
          pat_bytes[pat_len] = it.ch;
          pat_len++;
        end else begin
          pat_trunc = 1'b1;
        end
      end
      KIND_URL: begin
        pend = (url_seen == 0) ? (pat_len == 0) : url_pend;
        if (pend && it.ch == SLASH_BYTE) url_found = 1'b1;
        for (k = PAT_DEPTH; k > 0; k--) url_win[k] = url_win[k-1];
        url_win[0] = it.ch;
        if (url_seen < PAT_DEPTH + 1) url_seen++;
        here     = pattern_ends_here();
        url_pend = here;
        if (it.last) begin
          v.matched           = url_found || (here && pat_len > 0);
          v.pattern_truncated = pat_trunc;
          verdict_q = {verdict_q, v};
          url_seen  = 0;
          url_found = 1'b0;
          url_pend  = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  // idle length: mostly short, now and then long
  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
  endfunction

  // byte mix that makes matches and boundaries likely
  function automatic logic [7:0] pick_char();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return 8'h61;
    if (r < 7) return 8'h62;
    if (r == 7) return DOT_BYTE;
    if (r == 8) return SLASH_BYTE;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void push_item(input logic [1:0] kind, input logic [7:0] ch,
                                    input logic last);
    stream_item_t it;
    it.kind = kind;
    it.ch   = ch;
    it.last = last;
    item_q = {item_q, it};
    if (kind != KIND_UNUSED) items_made++;
  endfunction

  // clear, then a new pattern; now and then longer than the store
  function automatic void load_pattern();
    int unsigned n;
    int unsigned k;
    logic [7:0]  c;
    n = ($urandom_range(0, 14) == 0) ? $urandom_range(60, 68) : $urandom_range(0, 5);
    push_item(KIND_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    gen_pat.delete();
    for (k = 0; k < n; k++) begin
      c = pick_char();
      push_item(KIND_APPEND, c, 1'($urandom_range(0, 1)));
      if (gen_pat.size() < PAT_DEPTH) gen_pat = {gen_pat, c};
    end
  endfunction

  // one url: mostly the pattern with proper boundaries, some broken, some noise
  function automatic void send_url();
    logic [7:0]  u[$];
    logic [7:0]  c;
    int unsigned style;
    int unsigned tail;
    int unsigned n;
    int unsigned k;
    style = $urandom_range(0, 9);
    n = ($urandom_range(0, 15) == 0) ? $urandom_range(50, 80) : $urandom_range(0, 5);
    for (k = 0; k < n; k++) u = {u, pick_char()};
    if (style < 8) begin
      if (u.size() > 0) u = {u, (style < 6) ? DOT_BYTE : pick_char()};
      for (k = 0; k < gen_pat.size(); k++) u = {u, gen_pat[k]};
      tail = (style < 6) ? $urandom_range(0, 1) : $urandom_range(0, 2);
      if (tail != 0) begin
        u = {u, (tail == 1) ? SLASH_BYTE : pick_char()};
        n = $urandom_range(0, 4);
        for (k = 0; k < n; k++) u = {u, pick_char()};
      end
    end
    if (u.size() == 0) u = {u, pick_char()};
    for (k = 0; k < u.size(); k++) begin
      // pattern edits and unused kinds in the middle of a url
      if ($urandom_range(0, 24) == 0) begin
        case ($urandom_range(0, 2))
          0: push_item(KIND_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
          1: begin
            c = pick_char();
            push_item(KIND_APPEND, c, 1'($urandom_range(0, 1)));
            if (gen_pat.size() < PAT_DEPTH) gen_pat = {gen_pat, c};
          end
          default: begin
            push_item(KIND_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            gen_pat.delete();
          end
        endcase
      end
      push_item(KIND_URL, u[k], k == u.size() - 1);
    end
  endfunction

  function automatic void run_until(input int unsigned target);
    while (items_made < target) begin
      if ($urandom_range(0, 9) != 0) load_pattern();
      repeat ($urandom_range(1, 4)) send_url();
      if ($urandom_range(0, 9) == 0)
        push_item(KIND_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
  endfunction

  // sender pause: all items taken and every verdict received
  task automatic drain();
    do @(negedge clk_i);
    while (item_q.size() != 0 || in_if.valid || verdict_q.size() != 0);
  endtask

  // input driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      gap_left    <= 0;
    end else begin
      if (in_if.valid && in_if.ready) track_item(cur_item);
      if (in_if.valid && !in_if.ready) begin
        // transaction still offered
      end else if (gap_left > 0) begin
        gap_left    <= gap_left - 1;
        in_if.valid <= 1'b0;
      end else if (item_q.size() > 0) begin
        cur_item      <= item_q[0];
        in_if.kind    <= item_q[0].kind;
        in_if.char_in <= item_q[0].ch;
        in_if.last    <= item_q[0].last;
        in_if.valid   <= 1'b1;
        void'(item_q.pop_front());
        gap_left <= (send_idle && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk_i) begin
    verdict_t exp_v;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left   <= 0;
      hold_cnt     <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (verdict_q.size() == 0) begin
          $error("result transaction with no verdict pending");
          fail_cnt++;
        end else begin
          exp_v = verdict_q.pop_front();
          if (out_if.matched !== exp_v.matched) begin
            $error("matched: expected %0b, actual %0b", exp_v.matched, out_if.matched);
            fail_cnt++;
          end
          if (out_if.pattern_truncated !== exp_v.pattern_truncated) begin
            $error("pattern_truncated: expected %0b, actual %0b",
                   exp_v.pattern_truncated, out_if.pattern_truncated);
            fail_cnt++;
          end
        end
      end
      if (hold_req) begin
        hold_cnt     <= LONG_HOLD;
        out_if.ready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt     <= hold_cnt - 1;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left   <= stall_left - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (recv_idle && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus and end of run
  initial begin
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.kind     = KIND_CLEAR;
    in_if.char_in  = 8'h00;
    in_if.last     = 1'b0;
    out_if.ready   = 1'b0;
    send_idle      = 1'b1;
    recv_idle      = 1'b1;
    hold_req       = 1'b0;
    items_made     = 0;
    fail_cnt       = 0;
    pat_len        = 0;
    pat_trunc      = 1'b0;
    url_seen       = 0;
    url_found      = 1'b0;
    url_pend       = 1'b0;
    for (int k = 0; k < PAT_DEPTH; k++) pat_bytes[k] = 8'h00;
    for (int k = 0; k <= PAT_DEPTH; k++) url_win[k] = 8'h00;

    // directed: unused kind, empty pattern, extreme bytes, edits mid-url
    push_item(KIND_UNUSED, 8'h7A, 1'b1);
    push_item(KIND_URL, SLASH_BYTE, 1'b1);
    push_item(KIND_URL, 8'hFF, 1'b0);
    push_item(KIND_URL, 8'h00, 1'b1);
    push_item(KIND_APPEND, 8'h61, 1'b1);
    push_item(KIND_APPEND, 8'h62, 1'b0);
    push_item(KIND_URL, DOT_BYTE, 1'b0);
    push_item(KIND_URL, 8'h61, 1'b0);
    push_item(KIND_URL, 8'h62, 1'b1);
    push_item(KIND_URL, 8'h61, 1'b0);
    push_item(KIND_CLEAR, 8'hFF, 1'b1);
    push_item(KIND_APPEND, 8'h61, 1'b0);
    push_item(KIND_URL, 8'h61, 1'b0);
    push_item(KIND_URL, SLASH_BYTE, 1'b1);
    push_item(KIND_CLEAR, 8'h00, 1'b0);
    push_item(KIND_APPEND, 8'hFF, 1'b0);
    push_item(KIND_APPEND, 8'h00, 1'b0);
    push_item(KIND_URL, 8'hFF, 1'b0);
    push_item(KIND_URL, 8'h00, 1'b0);
    push_item(KIND_URL, SLASH_BYTE, 1'b1);
    push_item(KIND_CLEAR, 8'h55, 1'b0);

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // random traffic with idling on both sides
    run_until(300);
    drain();

    // long receiver hold-off while the sender keeps offering
    send_idle = 1'b0;
    hold_req  = 1'b1;
    load_pattern();
    repeat (10) send_url();
    @(negedge clk_i);
    hold_req = 1'b0;
    drain();

    // no idling at all
    recv_idle = 1'b0;
    run_until(550);
    drain();

    // idling again to the end
    send_idle = 1'b1;
    recv_idle = 1'b1;
    run_until(850);
    drain();
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/bdpm_pkg.sv
rtl/core/bdpm_if.sv
rtl/core/bdpm_match.sv
rtl/core/bounded_domain_pattern_match.sv
tb/sv/tb.sv
